/* rtl/resampling_voice_mixer_top_macros.svh */
// Assertion macros for the mixer RTL, used by the remainder unit
`ifndef RESAMPLING_VOICE_MIXER_TOP_MACROS_SVH
`define RESAMPLING_VOICE_MIXER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define RVM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RVM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rvm_pkg.sv */
// Shared types, codes and field layout of the voice mixer
package rvm_pkg;

    localparam int VOICE_COUNT_DEF  = 8;
    localparam int SAMPLE_DEPTH_DEF = 65536;

    localparam int IDX_W      = 18;
    localparam int CURSOR_W   = 50;
    localparam int STEP_W     = 40;
    localparam int LEN_W      = 17;
    localparam int MAX_FRAMES = 65536;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    localparam int OFS_VOICE   = 0;
    localparam int OFS_ADDRESS = 3;
    localparam int OFS_SAMPLE  = 19;
    localparam int OFS_IS_BYTE = 35;
    localparam int OFS_FRAMES  = 36;
    localparam int OFS_STEREO  = 53;
    localparam int OFS_STEP    = 54;
    localparam int OFS_LGAIN   = 94;
    localparam int OFS_RGAIN   = 110;
    localparam int OFS_LOOPING = 126;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_SETUP  = 2'd1,
        FUNC_STOP   = 2'd2,
        FUNC_RENDER = 2'd3
    } func_t;

    typedef struct packed {
        logic       load_now;
        logic       load_start;
        logic       load_write;
        logic       setup;
        logic       halt;
        logic       start_render;
        logic       stop_voice;
        logic       wrap_start;
        logic       wrap_load;
        logic       addr_start;
        logic       addr_load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       interp;
        logic       gain;
        logic       accum;
        logic       next_voice;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic playing;
        logic len_zero;
        logic past_end;
        logic looping;
        logic rem_done;
        logic last_voice;
        logic out_free;
        logic addr_direct;
    } sts_t;

endpackage

/* rtl/rvm_rem.sv */
// Restoring remainder unit, one dividend bit per cycle
`include "resampling_voice_mixer_top_macros.svh"

module rvm_rem #(
    parameter int REM_W = 17
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rvm_pkg::IDX_W-1:0]   dividend,
    input  logic [REM_W-1:0]            divisor,
    output logic [REM_W-1:0]            rem,
    output logic                        done
);

    localparam int DVW = rvm_pkg::IDX_W;
    localparam int CW  = $clog2(DVW + 1);

    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVW-1:0]   num_reg;
    logic [REM_W-1:0] div_reg;
    logic [REM_W-1:0] r_reg;
    logic [REM_W:0]   trial;
    logic [REM_W-1:0] r_next;

    assign trial  = {r_reg, num_reg[DVW-1]};
    assign r_next = (trial >= {1'b0, div_reg}) ? REM_W'(trial - {1'b0, div_reg})
                                               : REM_W'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DVW);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CW'(1));
            done_reg <= (cnt_reg == CW'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            div_reg <= divisor;
            r_reg   <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DVW-2:0], 1'b0};
            r_reg   <= r_next;
        end
    end

    assign rem  = r_reg;
    assign done = done_reg;

    `RVM_ASSERT_IMP(a_start_idle, aclk, aresetn, start, !busy_reg, "remainder restarted while busy")
    `RVM_ASSERT_NXT(a_start_busy, aclk, aresetn, start, busy_reg && !done_reg, "remainder did not start")
    `RVM_ASSERT_IMP(a_rem_range, aclk, aresetn, done_reg, r_reg < div_reg, "remainder not below divisor")

endmodule

/* rtl/rvm_dp.sv */
// Mixer datapath: sample memory, voice state, interpolation, gain and mix
module rvm_dp #(
    parameter int VOICE_COUNT  = rvm_pkg::VOICE_COUNT_DEF,
    parameter int SAMPLE_DEPTH = rvm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rvm_pkg::S_TDATA_W-1:0] s_tdata,
    input  rvm_pkg::cmd_t                 cmd,
    output rvm_pkg::sts_t                 sts,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [rvm_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int VW     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int AW     = $clog2(SAMPLE_DEPTH);
    localparam int SUMW   = (AW > rvm_pkg::IDX_W) ? AW : rvm_pkg::IDX_W;
    localparam int ACCW   = 19 + VW;
    localparam int CW     = rvm_pkg::CURSOR_W;
    localparam int LW     = rvm_pkg::LEN_W;
    localparam bit DIRECT = ((SAMPLE_DEPTH & (SAMPLE_DEPTH - 1)) == 0);

    localparam int     MOD_XW = rvm_pkg::IDX_W;
    localparam int     MOD_MW = MOD_XW + 1;
    localparam int     MOD_PW = MOD_XW + MOD_MW;
    localparam int     MOD_SH = MOD_XW + AW;
    localparam longint MOD_M  = ((longint'(1) <<< MOD_SH) + longint'(SAMPLE_DEPTH) - longint'(1))
                              / longint'(SAMPLE_DEPTH);
    localparam logic [MOD_MW-1:0] MOD_MV = MOD_MW'(MOD_M);

    // input fields
    logic [2:0]                   in_voice;
    logic [15:0]                  in_address;
    logic [15:0]                  in_sample;
    logic                         in_is_byte;
    logic [LW-1:0]                in_frames;
    logic                         in_stereo;
    logic [rvm_pkg::STEP_W-1:0]   in_step;
    logic [15:0]                  in_lgain;
    logic [15:0]                  in_rgain;
    logic                         in_looping;
    logic [15:0]                  in_word;
    logic [LW-1:0]                in_len;
    logic                         in_voice_ok;
    logic [VW-1:0]                in_vidx;

    assign in_voice   = s_tdata[rvm_pkg::OFS_VOICE +: 3];
    assign in_address = s_tdata[rvm_pkg::OFS_ADDRESS +: 16];
    assign in_sample  = s_tdata[rvm_pkg::OFS_SAMPLE +: 16];
    assign in_is_byte = s_tdata[rvm_pkg::OFS_IS_BYTE];
    assign in_frames  = s_tdata[rvm_pkg::OFS_FRAMES +: LW];
    assign in_stereo  = s_tdata[rvm_pkg::OFS_STEREO];
    assign in_step    = s_tdata[rvm_pkg::OFS_STEP +: rvm_pkg::STEP_W];
    assign in_lgain   = s_tdata[rvm_pkg::OFS_LGAIN +: 16];
    assign in_rgain   = s_tdata[rvm_pkg::OFS_RGAIN +: 16];
    assign in_looping = s_tdata[rvm_pkg::OFS_LOOPING];

    assign in_word     = in_is_byte ? {in_sample[7:0] ^ 8'h80, 8'h00} : in_sample;
    assign in_len      = (in_frames > LW'(rvm_pkg::MAX_FRAMES)) ? LW'(rvm_pkg::MAX_FRAMES)
                                                                : in_frames;
    assign in_voice_ok = (6'(in_voice) < 6'(VOICE_COUNT));
    assign in_vidx     = VW'(in_voice);

    // voice state
    logic [15:0]                 start_reg   [VOICE_COUNT];
    logic [LW-1:0]               len_reg     [VOICE_COUNT];
    logic                        stereo_reg  [VOICE_COUNT];
    logic [rvm_pkg::STEP_W-1:0]  step_reg    [VOICE_COUNT];
    logic [15:0]                 lgain_reg   [VOICE_COUNT];
    logic [15:0]                 rgain_reg   [VOICE_COUNT];
    logic                        loop_reg    [VOICE_COUNT];
    logic [CW-1:0]               cursor_reg  [VOICE_COUNT];
    logic [VOICE_COUNT-1:0]      playing_reg;
    logic [VW-1:0]               vidx_reg;

    logic [CW-1:0]               cur;
    logic [rvm_pkg::IDX_W-1:0]   idx;
    logic [7:0]                  frac;
    logic [LW-1:0]               len_cur;
    logic                        st_cur;
    logic [rvm_pkg::IDX_W-1:0]   idx_p1;
    logic                        has_next;
    logic [SUMW-1:0]             base_sum;

    assign cur      = cursor_reg[vidx_reg];
    assign idx      = cur[CW-1:32];
    assign frac     = cur[31:24];
    assign len_cur  = len_reg[vidx_reg];
    assign st_cur   = stereo_reg[vidx_reg];
    assign idx_p1   = idx + 1'b1;
    assign has_next = (idx_p1 < rvm_pkg::IDX_W'(len_cur));
    assign base_sum = SUMW'(start_reg[vidx_reg])
                    + (st_cur ? SUMW'({idx, 1'b0}) : SUMW'(idx));

    // remainder unit for the cursor wrap
    logic                        rem_start;
    logic [rvm_pkg::IDX_W-1:0]   rem_dividend;
    logic [LW-1:0]               rem_divisor;
    logic [LW-1:0]               rem;
    logic                        rem_done;

    assign rem_start    = cmd.wrap_start;
    assign rem_dividend = idx;
    assign rem_divisor  = len_cur;

    rvm_rem #(
        .REM_W(LW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .rem      (rem),
        .done     (rem_done)
    );

    // address reduction modulo the memory depth by reciprocal multiplication
    logic                   mod_start;
    logic [MOD_XW-1:0]      mod_x;
    logic [MOD_PW-1:0]      mod_prod;
    logic [MOD_PW-1:0]      mod_qd;
    logic [MOD_XW-1:0]      mod_x_reg;
    logic [MOD_XW-1:0]      mod_q_reg;
    logic                   mod_v_reg;
    logic [AW-1:0]          mod_r_reg;
    logic                   mod_done_reg;

    assign mod_start = cmd.load_start | cmd.addr_start;
    assign mod_x     = cmd.addr_start ? MOD_XW'(base_sum) : MOD_XW'(in_address);
    assign mod_prod  = MOD_PW'(mod_x) * MOD_PW'(MOD_MV);
    assign mod_qd    = MOD_PW'(mod_q_reg) * MOD_PW'(SAMPLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_v_reg    <= 1'b0;
            mod_done_reg <= 1'b0;
        end else begin
            mod_v_reg    <= mod_start;
            mod_done_reg <= mod_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mod_start) begin
            mod_x_reg <= mod_x;
            mod_q_reg <= MOD_XW'(mod_prod >> MOD_SH);
        end
        if (mod_v_reg) begin
            mod_r_reg <= AW'(MOD_PW'(mod_x_reg) - mod_qd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg <= '0;
            vidx_reg    <= '0;
        end else begin
            if (cmd.setup && in_voice_ok) begin
                playing_reg[in_vidx] <= (in_len != '0);
            end
            if (cmd.halt && in_voice_ok) begin
                playing_reg[in_vidx] <= 1'b0;
            end
            if (cmd.stop_voice) begin
                playing_reg[vidx_reg] <= 1'b0;
            end
            if (cmd.start_render) begin
                vidx_reg <= '0;
            end else if (cmd.next_voice) begin
                vidx_reg <= vidx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup && in_voice_ok) begin
            start_reg[in_vidx]  <= in_address;
            len_reg[in_vidx]    <= in_len;
            stereo_reg[in_vidx] <= in_stereo;
            step_reg[in_vidx]   <= in_step;
            lgain_reg[in_vidx]  <= in_lgain;
            rgain_reg[in_vidx]  <= in_rgain;
            loop_reg[in_vidx]   <= in_looping;
            cursor_reg[in_vidx] <= '0;
        end
        if (cmd.halt && in_voice_ok) begin
            cursor_reg[in_vidx] <= '0;
        end
        if (cmd.stop_voice) begin
            cursor_reg[vidx_reg] <= '0;
        end
        if (cmd.wrap_load) begin
            cursor_reg[vidx_reg] <= {rvm_pkg::IDX_W'(rem), cur[31:0]};
        end
        if (cmd.accum) begin
            cursor_reg[vidx_reg] <= CW'(cur + CW'(step_reg[vidx_reg]));
        end
    end

    // sample memory
    logic [15:0]   mem [SAMPLE_DEPTH];
    logic [15:0]   mem_q;
    logic [15:0]   ld_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic [AW-1:0] base_reg;
    logic [1:0]    rd_off;
    logic [AW:0]   ra_sum;
    logic [AW-1:0] mem_ra;

    assign mem_we = cmd.load_now | cmd.load_write;
    assign mem_wa = cmd.load_write ? mod_r_reg : AW'(in_address);
    assign mem_wd = cmd.load_write ? ld_data_reg : in_word;

    always_comb begin
        case (cmd.rd_sel)
            2'd0:    rd_off = 2'd0;
            2'd1:    rd_off = {1'b0, st_cur};
            2'd2:    rd_off = has_next ? (st_cur ? 2'd2 : 2'd1) : 2'd0;
            default: rd_off = (has_next ? (st_cur ? 2'd2 : 2'd1) : 2'd0) + {1'b0, st_cur};
        endcase
    end

    assign ra_sum = {1'b0, base_reg} + (AW + 1)'(rd_off);
    assign mem_ra = (ra_sum >= (AW + 1)'(SAMPLE_DEPTH))
                  ? AW'(ra_sum - (AW + 1)'(SAMPLE_DEPTH)) : AW'(ra_sum);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_en) begin
            mem_q <= mem[mem_ra];
        end
        if (cmd.load_start) begin
            ld_data_reg <= in_word;
        end
        if (cmd.addr_load) begin
            base_reg <= DIRECT ? AW'(base_sum) : mod_r_reg;
        end
    end

    // interpolation and gain
    logic signed [15:0] l0_reg, r0_reg, l1_reg, r1_reg;
    logic signed [16:0] dl, dr;
    logic signed [25:0] pl_reg, pr_reg;
    logic signed [17:0] lv, rv;
    logic signed [35:0] gl_reg, gr_reg;
    logic signed [ACCW-1:0] accl_reg, accr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            case (cmd.cap_sel)
                2'd0:    l0_reg <= mem_q;
                2'd1:    r0_reg <= mem_q;
                2'd2:    l1_reg <= mem_q;
                default: r1_reg <= mem_q;
            endcase
        end
    end

    assign dl = 17'(l1_reg) - 17'(l0_reg);
    assign dr = 17'(r1_reg) - 17'(r0_reg);
    assign lv = 18'(l0_reg) + 18'(pl_reg >>> 8);
    assign rv = 18'(r0_reg) + 18'(pr_reg >>> 8);

    always_ff @(posedge aclk) begin
        if (cmd.interp) begin
            pl_reg <= dl * $signed({1'b0, frac});
            pr_reg <= dr * $signed({1'b0, frac});
        end
        if (cmd.gain) begin
            gl_reg <= lv * $signed({1'b0, lgain_reg[vidx_reg]});
            gr_reg <= rv * $signed({1'b0, rgain_reg[vidx_reg]});
        end
        if (cmd.start_render) begin
            accl_reg <= '0;
            accr_reg <= '0;
        end else if (cmd.accum) begin
            accl_reg <= accl_reg + ACCW'(gl_reg >>> 15);
            accr_reg <= accr_reg + ACCW'(gr_reg >>> 15);
        end
    end

    // output register
    logic [15:0]              left_sat, right_sat;
    logic [VOICE_COUNT+7:0]   mask_pad;
    logic                     m_tvalid_reg;
    logic [rvm_pkg::M_TDATA_W-1:0] m_tdata_reg;

    assign left_sat  = (accl_reg < -ACCW'(32768)) ? 16'h8000
                     : (accl_reg > ACCW'(32767))  ? 16'h7fff : 16'(accl_reg);
    assign right_sat = (accr_reg < -ACCW'(32768)) ? 16'h8000
                     : (accr_reg > ACCW'(32767))  ? 16'h7fff : 16'(accr_reg);
    assign mask_pad  = {8'h00, playing_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {mask_pad[7:0], right_sat, left_sat};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign sts.playing     = playing_reg[vidx_reg];
    assign sts.len_zero    = (len_cur == '0);
    assign sts.past_end    = (idx >= rvm_pkg::IDX_W'(len_cur));
    assign sts.looping     = loop_reg[vidx_reg];
    assign sts.rem_done    = rem_done | mod_done_reg;
    assign sts.last_voice  = (vidx_reg == VW'(VOICE_COUNT - 1));
    assign sts.out_free    = !m_tvalid_reg || m_tready;
    assign sts.addr_direct = DIRECT;

endmodule

/* rtl/rvm_ctrl.sv */
// Mixer controller: sequences items and the per-voice render steps
module rvm_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [rvm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          s_tready,
    input  rvm_pkg::sts_t                 sts,
    output rvm_pkg::cmd_t                 cmd
);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_LOADW = 16'h0002,
        ST_CHECK = 16'h0004,
        ST_WRAPW = 16'h0008,
        ST_ADDR  = 16'h0010,
        ST_ADDRW = 16'h0020,
        ST_RD0   = 16'h0040,
        ST_RD1   = 16'h0080,
        ST_RD2   = 16'h0100,
        ST_RD3   = 16'h0200,
        ST_RDW   = 16'h0400,
        ST_INTP  = 16'h0800,
        ST_GAIN  = 16'h1000,
        ST_ACCUM = 16'h2000,
        ST_NEXT  = 16'h4000,
        ST_OUT   = 16'h8000
    } state_t;

    state_t         state_reg, state_next;
    rvm_pkg::func_t func;
    logic           accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign func     = rvm_pkg::func_t'(s_tuser);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (func)
                        rvm_pkg::FUNC_LOAD: begin
                            if (sts.addr_direct) begin
                                cmd.load_now = 1'b1;
                            end else begin
                                cmd.load_start = 1'b1;
                                state_next     = ST_LOADW;
                            end
                        end
                        rvm_pkg::FUNC_SETUP: cmd.setup = 1'b1;
                        rvm_pkg::FUNC_STOP:  cmd.halt  = 1'b1;
                        default: begin
                            cmd.start_render = 1'b1;
                            state_next       = ST_CHECK;
                        end
                    endcase
                end
            end
            ST_LOADW: begin
                if (sts.rem_done) begin
                    cmd.load_write = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (!sts.playing) begin
                    state_next = ST_NEXT;
                end else if (sts.len_zero || (sts.past_end && !sts.looping)) begin
                    cmd.stop_voice = 1'b1;
                    state_next     = ST_NEXT;
                end else if (sts.past_end) begin
                    cmd.wrap_start = 1'b1;
                    state_next     = ST_WRAPW;
                end else begin
                    state_next = ST_ADDR;
                end
            end
            ST_WRAPW: begin
                if (sts.rem_done) begin
                    cmd.wrap_load = 1'b1;
                    state_next    = ST_ADDR;
                end
            end
            ST_ADDR: begin
                if (sts.addr_direct) begin
                    cmd.addr_load = 1'b1;
                    state_next    = ST_RD0;
                end else begin
                    cmd.addr_start = 1'b1;
                    state_next     = ST_ADDRW;
                end
            end
            ST_ADDRW: begin
                if (sts.rem_done) begin
                    cmd.addr_load = 1'b1;
                    state_next    = ST_RD0;
                end
            end
            ST_RD0: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 2'd0;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd1;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd0;
                state_next  = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd2;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd1;
                state_next  = ST_RD3;
            end
            ST_RD3: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd3;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd2;
                state_next  = ST_RDW;
            end
            ST_RDW: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd3;
                state_next  = ST_INTP;
            end
            ST_INTP: begin
                cmd.interp = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (sts.last_voice) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.next_voice = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/resampling_voice_mixer_top.sv */
// Render: a beat is taken only when idle; a playing voice takes more steps than a silent one.
// m_tvalid rises in the same cycle as s_tready returns high; a held frame stalls the sequencer.
// A looping voice that wraps passes through the serial remainder unit.
// A non-power-of-two memory depth adds an address reduction per playing voice and per load.
// Reset (aresetn low, synchronous) stops all voices
// and empties the output; sample memory keeps its contents.
module resampling_voice_mixer_top #(
    parameter int VOICE_COUNT  = rvm_pkg::VOICE_COUNT_DEF,
    parameter int SAMPLE_DEPTH = rvm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // voice, address, sample_value, sample_is_byte, frame_count, stereo,
    // step, left_gain, right_gain, looping
    input  logic [rvm_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [rvm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // left_out, right_out, playing_mask
    output logic [rvm_pkg::M_TDATA_W-1:0] m_tdata
);

    rvm_pkg::cmd_t cmd;
    rvm_pkg::sts_t sts;

    rvm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rvm_dp #(
        .VOICE_COUNT  (VOICE_COUNT),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

/* tb/sv/resampling_voice_mixer_top_tb.sv */
// Self-checking testbench for the resampling voice mixer: directed table, then random traffic
module resampling_voice_mixer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVOICE     = 8;
    localparam int WATCHDOG   = 20000;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        rvm_pkg::func_t func;
        logic [2:0]  voice;
        logic [15:0] address;
        logic [15:0] sample_value;
        logic        sample_is_byte;
        logic [16:0] frame_count;
        logic        stereo;
        logic [39:0] step;
        logic [15:0] left_gain;
        logic [15:0] right_gain;
        logic        looping;
    } beat_in_t;

    typedef struct packed {
        logic [15:0] left_out;
        logic [15:0] right_out;
        logic [7:0]  playing_mask;
    } mix_frame_t;

    typedef struct {
        beat_in_t   item;
        logic       typed;
        mix_frame_t want;
    } table_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rvm_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [rvm_pkg::S_TUSER_W-1:0]   s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rvm_pkg::M_TDATA_W-1:0]   m_tdata;

    resampling_voice_mixer_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mixer state mirror
    logic [15:0] wave_mem [0:65535];
    bit          wave_written [0:65535];
    logic [15:0] v_start [NVOICE];
    logic [16:0] v_len [NVOICE];
    logic        v_stereo [NVOICE];
    logic [39:0] v_step [NVOICE];
    logic [15:0] v_gl [NVOICE];
    logic [15:0] v_gr [NVOICE];
    logic        v_loop [NVOICE];
    logic        v_play [NVOICE];
    logic [49:0] v_cur [NVOICE];

    mix_frame_t  frame_q [$];
    logic        frame_typed_q [$];
    mix_frame_t  typed_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic longint floor_sh(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint wave_word(longint a);
        logic [15:0] w;
        w = wave_mem[a & 65535];
        return longint'($signed(w));
    endfunction

    function automatic mix_frame_t mix_apply(beat_in_t b);
        mix_frame_t r;
        longint accl, accr, idx, nxt, ch, base, l0, r0, l1, r1, fr, lv, rv;
        logic [49:0] lim;
        logic [16:0] len;
        r = '{16'd0, 16'd0, 8'd0};
        case (b.func)
            rvm_pkg::FUNC_LOAD: begin
                wave_mem[b.address] = b.sample_is_byte ?
                    {b.sample_value[7:0] ^ 8'h80, 8'h00} : b.sample_value;
                wave_written[b.address] = 1'b1;
            end
            rvm_pkg::FUNC_SETUP: begin
                len = (b.frame_count > 17'd65536) ? 17'd65536 : b.frame_count;
                v_start[b.voice] = b.address;
                v_len[b.voice] = len;
                v_stereo[b.voice] = b.stereo;
                v_step[b.voice] = b.step;
                v_gl[b.voice] = b.left_gain;
                v_gr[b.voice] = b.right_gain;
                v_loop[b.voice] = b.looping;
                v_cur[b.voice] = '0;
                v_play[b.voice] = (len != 0);
            end
            rvm_pkg::FUNC_STOP: begin
                v_play[b.voice] = 1'b0;
                v_cur[b.voice] = '0;
            end
            default: begin
                accl = 0;
                accr = 0;
                for (int i = 0; i < NVOICE; i++) begin
                    if (!v_play[i]) continue;
                    if (v_len[i] == 0) begin
                        v_play[i] = 1'b0;
                        v_cur[i] = '0;
                        continue;
                    end
                    lim = {v_len[i], 32'd0};
                    if (v_cur[i] >= lim) begin
                        if (v_loop[i]) begin
                            v_cur[i] = v_cur[i] % lim;
                        end else begin
                            v_play[i] = 1'b0;
                            v_cur[i] = '0;
                            continue;
                        end
                    end
                    idx = longint'(v_cur[i] >> 32);
                    fr = longint'(v_cur[i][31:24]);
                    nxt = (idx + 1 < longint'(v_len[i])) ? idx + 1 : idx;
                    ch = v_stereo[i] ? 2 : 1;
                    base = longint'(v_start[i]) + idx * ch;
                    l0 = wave_word(base);
                    r0 = v_stereo[i] ? wave_word(base + 1) : l0;
                    base = longint'(v_start[i]) + nxt * ch;
                    l1 = wave_word(base);
                    r1 = v_stereo[i] ? wave_word(base + 1) : l1;
                    lv = l0 + floor_sh((l1 - l0) * fr, 8);
                    rv = r0 + floor_sh((r1 - r0) * fr, 8);
                    accl += floor_sh(lv * longint'(v_gl[i]), 15);
                    accr += floor_sh(rv * longint'(v_gr[i]), 15);
                    v_cur[i] = v_cur[i] + 50'(v_step[i]);
                end
                for (int i = 0; i < NVOICE; i++) r.playing_mask[i] = v_play[i];
                if (accl < -32768) accl = -32768;
                if (accl > 32767) accl = 32767;
                if (accr < -32768) accr = -32768;
                if (accr > 32767) accr = 32767;
                r.left_out = accl[15:0];
                r.right_out = accr[15:0];
            end
        endcase
        return r;
    endfunction

    function automatic logic [rvm_pkg::S_TDATA_W-1:0] pack_beat(beat_in_t b);
        logic [rvm_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[rvm_pkg::OFS_VOICE +: 3] = b.voice;
        d[rvm_pkg::OFS_ADDRESS +: 16] = b.address;
        d[rvm_pkg::OFS_SAMPLE +: 16] = b.sample_value;
        d[rvm_pkg::OFS_IS_BYTE] = b.sample_is_byte;
        d[rvm_pkg::OFS_FRAMES +: 17] = b.frame_count;
        d[rvm_pkg::OFS_STEREO] = b.stereo;
        d[rvm_pkg::OFS_STEP +: 40] = b.step;
        d[rvm_pkg::OFS_LGAIN +: 16] = b.left_gain;
        d[rvm_pkg::OFS_RGAIN +: 16] = b.right_gain;
        d[rvm_pkg::OFS_LOOPING] = b.looping;
        return d;
    endfunction

    function automatic beat_in_t blank_beat(rvm_pkg::func_t f);
        beat_in_t b;
        b = '{f, 3'd0, 16'd0, 16'd0, 1'b0, 17'd0, 1'b0, 40'd0, 16'd0, 16'd0, 1'b0};
        return b;
    endfunction

    // accept one input beat and record what it should produce
    task automatic send_beat(beat_in_t b, logic typed, mix_frame_t want);
        mix_frame_t got_pred;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom, $urandom, $urandom};
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_beat(b);
        s_tuser <= b.func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got_pred = mix_apply(b);
        if (b.func == rvm_pkg::FUNC_RENDER) begin
            frame_q.push_back(got_pred);
            frame_typed_q.push_back(typed);
            if (typed) typed_q.push_back(want);
        end
    endtask

    always @(posedge aclk) begin
        mix_frame_t w, tw;
        logic t;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (frame_q.size() == 0) begin
                    $display("%0t: unexpected frame %h", $realtime, m_tdata);
                    errors++;
                end else begin
                    w = frame_q.pop_front();
                    t = frame_typed_q.pop_front();
                    if (t) begin
                        tw = typed_q.pop_front();
                        if (tw != w) begin
                            $display("%0t: table row exp %h/%h/%h model %h/%h/%h", $realtime,
                                     tw.left_out, tw.right_out, tw.playing_mask,
                                     w.left_out, w.right_out, w.playing_mask);
                            errors++;
                        end
                    end
                    if (m_tdata[15:0] !== w.left_out) begin
                        $display("%0t: left_out exp %h got %h", $realtime, w.left_out,
                                 m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[31:16] !== w.right_out) begin
                        $display("%0t: right_out exp %h got %h", $realtime, w.right_out,
                                 m_tdata[31:16]);
                        errors++;
                    end
                    if (m_tdata[39:32] !== w.playing_mask) begin
                        $display("%0t: playing_mask exp %h got %h", $realtime,
                                 w.playing_mask, m_tdata[39:32]);
                        errors++;
                    end
                end
            end
            m_tready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("resampling_voice_mixer_top regression: fail");
            $finish;
        end
    end

    table_row_t dir_tab [$];

    task automatic add_row(beat_in_t b, logic typed, logic [15:0] l, logic [15:0] r,
                           logic [7:0] m);
        dir_tab.push_back('{b, typed, '{l, r, m}});
    endtask

    task automatic build_table();
        beat_in_t b;
        b = blank_beat(rvm_pkg::FUNC_RENDER);
        add_row(b, 1'b1, 16'h0000, 16'h0000, 8'h00);
        b = blank_beat(rvm_pkg::FUNC_LOAD); b.address = 16'd0; b.sample_value = 16'h7FFF;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_LOAD); b.address = 16'd1; b.sample_value = 16'h8000;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_LOAD); b.address = 16'hFFFF; b.sample_value = 16'hFF;
        b.sample_is_byte = 1'b1;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_LOAD); b.address = 16'd2; b.sample_value = 16'hFF00;
        b.sample_is_byte = 1'b1;
        add_row(b, 1'b0, 0, 0, 0);
        // mono one-frame voice at maximum left and unity right gain holds max
        b = blank_beat(rvm_pkg::FUNC_SETUP); b.voice = 3'd0; b.frame_count = 17'd1;
        b.left_gain = 16'hFFFF; b.right_gain = 16'h8000;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_RENDER);
        add_row(b, 1'b1, 16'h7FFF, 16'h7FFF, 8'h01);
        add_row(b, 1'b1, 16'h7FFF, 16'h7FFF, 8'h01);
        b = blank_beat(rvm_pkg::FUNC_STOP); b.voice = 3'd0;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_RENDER);
        add_row(b, 1'b1, 16'h0000, 16'h0000, 8'h00);
        // looping stereo voice at address FFFF with a fractional step, stopped before it renders
        b = blank_beat(rvm_pkg::FUNC_SETUP); b.voice = 3'd7; b.address = 16'hFFFF;
        b.frame_count = 17'h1FFFF; b.stereo = 1'b1; b.step = 40'hFF_FFFF_FFFF;
        b.left_gain = 16'h8000; b.right_gain = 16'h8000; b.looping = 1'b1;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_SETUP); b.voice = 3'd3; b.frame_count = 17'd2;
        b.step = 40'h00_8000_0000; b.left_gain = 16'h8000; b.right_gain = 16'h4000;
        b.looping = 1'b1;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_SETUP); b.voice = 3'd5; b.frame_count = 17'd0;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_STOP); b.voice = 3'd7;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_RENDER);
        for (int i = 0; i < 5; i++) add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_SETUP); b.voice = 3'd1; b.address = 16'd1;
        b.frame_count = 17'd2;
        b.step = 40'h01_0000_0000; b.left_gain = 16'hFFFF; b.right_gain = 16'hFFFF;
        add_row(b, 1'b0, 0, 0, 0);
        b = blank_beat(rvm_pkg::FUNC_RENDER);
        for (int i = 0; i < 4; i++) add_row(b, 1'b0, 0, 0, 0);
    endtask

    function automatic beat_in_t rand_beat(int hot);
        beat_in_t b;
        int k;
        b = blank_beat(rvm_pkg::FUNC_RENDER);
        b.voice = 3'($urandom);
        b.sample_value = 16'($urandom);
        b.sample_is_byte = 1'($urandom);
        b.address = 16'($urandom_range(hot, 0));
        k = $urandom_range(99, 0);
        if (k < 30) begin
            b.func = rvm_pkg::FUNC_LOAD;
            if ($urandom_range(9, 0) == 0) b.address = 16'($urandom);
        end else if (k < 42) begin
            b.func = rvm_pkg::FUNC_SETUP;
            b.stereo = 1'($urandom);
            b.looping = 1'($urandom);
            b.frame_count = ($urandom_range(9, 0) == 0) ? 17'($urandom) :
                            17'($urandom_range(12, 0));
            b.step = ($urandom_range(7, 0) == 0) ? {8'($urandom), 32'($urandom)} :
                     {8'($urandom_range(2, 0)), 32'($urandom)};
            b.left_gain = 16'($urandom);
            b.right_gain = 16'($urandom);
        end else if (k < 47) begin
            b.func = rvm_pkg::FUNC_STOP;
        end
        return b;
    endfunction

    // write words 0 to 127, so that no read of a voice kept within them sees unwritten words
    task automatic fill_region();
        for (int a = 0; a < 128; a++) begin
            beat_in_t b;
            b = blank_beat(rvm_pkg::FUNC_LOAD);
            b.address = 16'(a);
            b.sample_value = 16'($urandom);
            send_beat(b, 1'b0, '{16'd0, 16'd0, 8'd0});
        end
    endtask

    function automatic logic region_safe(beat_in_t b);
        logic [16:0] len;
        longint top;
        len = (b.frame_count > 17'd65536) ? 17'd65536 : b.frame_count;
        top = longint'(b.address) + longint'(len) * (b.stereo ? 2 : 1);
        if (len == 0) return 1'b1;
        if (top <= 128) return 1'b1;
        for (longint a = b.address; a < top; a++)
            if (!wave_written[a & 65535]) return 1'b0;
        return 1'b1;
    endfunction

    initial begin
        beat_in_t b;
        for (int i = 0; i < 65536; i++) begin
            wave_mem[i] = '0;
            wave_written[i] = 1'b0;
        end
        for (int i = 0; i < NVOICE; i++) begin
            v_start[i] = '0; v_len[i] = '0; v_stereo[i] = 1'b0; v_step[i] = '0;
            v_gl[i] = '0; v_gr[i] = '0; v_loop[i] = 1'b0; v_play[i] = 1'b0; v_cur[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        m_tready <= 1'b1;
        @(posedge aclk);
        build_table();
        // rows run in order: a render, then the directed loads; the region is filled before row 10
        for (int i = 0; i < dir_tab.size(); i++) begin
            if (i == 10) fill_region();
            send_beat(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        end
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int n = 0; n < 400; n++) begin
                b = rand_beat(ph == 0 ? 127 : 255);
                if (b.func == rvm_pkg::FUNC_SETUP && !region_safe(b)) b.frame_count = 17'd0;
                send_beat(b, 1'b0, '{16'd0, 16'd0, 8'd0});
            end
        end
        s_tvalid <= 1'b0;
        send_idle_pct = 0;
        while (frame_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && frame_q.size() == 0) begin
            $display("resampling_voice_mixer_top regression: pass");
        end else begin
            $display("resampling_voice_mixer_top regression: fail");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/rvm_pkg.sv
rtl/rvm_rem.sv
rtl/rvm_dp.sv
rtl/rvm_ctrl.sv
rtl/resampling_voice_mixer_top.sv
tb/sv/resampling_voice_mixer_top_tb.sv
